[design/reciprocating_assist_drive_control_defines.svh]
// Assertion macros for the reciprocating assist drive control checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef RECIPROCATING_ASSIST_DRIVE_CONTROL_DEFINES_SVH
`define RECIPROCATING_ASSIST_DRIVE_CONTROL_DEFINES_SVH

// same-cycle implication, reset disables
`define RADC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radc assertion failed");

// next-cycle implication, reset disables
`define RADC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radc assertion failed");

`endif

[design/radc_pkg.sv]
// Shared types and constants for the reciprocating assist drive control.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package radc_pkg;

    typedef struct packed {
        logic signed [31:0] position;
        logic        [15:0] speed;
        logic               speed_ready;
    } in_item_t;

    typedef struct packed {
        logic               drive_write;
        logic signed [15:0] drive;
        logic        [1:0]  phase;
        logic        [15:0] cycles_done;
        logic               finished;
    } out_item_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_in;
        logic step_phase;
        logic mult;
        logic level;
        logic load_out;
    } dp_cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DRV  = 3'd4;

    localparam logic [1:0] PH_WAIT_FWD  = 2'd0;
    localparam logic [1:0] PH_DRIVE_FWD = 2'd1;
    localparam logic [1:0] PH_WAIT_BWD  = 2'd2;
    localparam logic [1:0] PH_DRIVE_BWD = 2'd3;

    localparam logic signed [31:0] POS_LOWER_LIMIT = 32'sd50;
    localparam logic signed [31:0] POS_UPPER_LIMIT = 32'sd17000;
    localparam logic signed [32:0] POS_MARGIN      = 33'sd50;

    localparam logic signed [31:0] START_POS_RST = 32'sd50;
    localparam logic signed [31:0] END_POS_RST   = 32'sd17000;
    localparam logic        [15:0] REPS_RST      = 16'd1;

    // gain 0.4297 and offset 11.5 in Q16
    localparam logic [14:0] GAIN_Q16   = 15'd28161;
    localparam logic [31:0] OFFSET_Q16 = 32'd753664;

    // level = c * 32768 / 100, saturates from c = 100 up
    localparam logic [15:0] LEVEL_SAT_C = 16'd100;
    // floor(c * 8192 / 25) = (c * ceil(2^25 / 25)) >> 12 for c < 100
    localparam logic [20:0] LEVEL_RECIP = 21'd1342178;
    localparam int          LEVEL_SHIFT = 12;

    localparam logic signed [15:0] LEVEL_MAX  = 16'sh7fff;
    localparam logic signed [15:0] LEVEL_MIN  = 16'sh8000;
    localparam logic signed [15:0] IDLE_LEVEL = 16'sd12;

    localparam logic [15:0] CYCLE_MAX = 16'hffff;

endpackage

`default_nettype wire

[design/radc_datapath.sv]
// Datapath: configuration registers, phase state, drive level adaptation
// and the output register. Depends on radc_pkg; driven by radc_ctrl.
`default_nettype none

module radc_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire radc_pkg::dp_cmd_t               cmd,
    output radc_pkg::dp_status_t                 status,
    input  wire radc_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output radc_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_we,
    input  wire logic [radc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [radc_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic signed [31:0] start_reg, start_next;
    logic signed [31:0] end_reg, end_next;
    logic        [15:0] reps_reg, reps_next;
    logic        [15:0] desired_reg, desired_next;

    radc_pkg::in_item_t in_reg, in_next;

    logic        [1:0]  phase_now_reg, phase_now_next;
    logic        [1:0]  next_phase_reg, next_phase_next;
    logic               entry_reg, entry_next;
    logic        [15:0] cyc_reg, cyc_next;
    logic signed [15:0] level_reg, level_next;
    logic signed [17:0] pred_reg, pred_next;
    logic               done_reg, done_next;

    logic               wr_reg, wr_next;
    logic signed [15:0] drv_reg, drv_next;
    logic               upd_reg, upd_next;
    logic               adapt_reg, adapt_next;
    logic        [17:0] err_reg, err_next;
    logic        [31:0] prod_reg, prod_next;

    logic               out_valid_reg, out_valid_next;
    radc_pkg::out_item_t out_item_reg, out_item_next;

    logic signed [31:0] min_pos, max_pos;
    logic signed [32:0] pos_w, min_hi, max_lo;
    logic               at_min, at_max;
    logic signed [18:0] spd_w, pred_w, des_w, diff, err_w, pn_a, pn_b;
    logic        [15:0] coef;
    logic        [27:0] scale_prod;
    logic signed [15:0] scaled;

    always_comb
    begin
        min_pos = (start_reg < radc_pkg::POS_LOWER_LIMIT) ? radc_pkg::POS_LOWER_LIMIT
                                                          : start_reg;
        max_pos = (end_reg > radc_pkg::POS_UPPER_LIMIT) ? radc_pkg::POS_UPPER_LIMIT
                                                        : end_reg;
        pos_w  = 33'(in_reg.position);
        min_hi = 33'(min_pos) + radc_pkg::POS_MARGIN;
        max_lo = 33'(max_pos) - radc_pkg::POS_MARGIN;
        at_min = in_reg.position <= min_pos;
        at_max = in_reg.position >= max_pos;

        spd_w  = $signed({3'b000, in_reg.speed});
        pred_w = 19'(pred_reg);
        des_w  = $signed({3'b000, desired_reg});
        diff   = spd_w - pred_w;
        err_w  = des_w - diff;
        pn_a   = des_w - diff;
        pn_b   = des_w - spd_w;

        coef       = prod_reg[31:16];
        scale_prod = 28'(coef[6:0]) * 28'(radc_pkg::LEVEL_RECIP);
        scaled     = $signed(16'(scale_prod >> radc_pkg::LEVEL_SHIFT));
    end

    always_comb
    begin
        start_next      = start_reg;
        end_next        = end_reg;
        reps_next       = reps_reg;
        desired_next    = desired_reg;
        in_next         = in_reg;
        phase_now_next  = phase_now_reg;
        next_phase_next = next_phase_reg;
        entry_next      = entry_reg;
        cyc_next        = cyc_reg;
        level_next      = level_reg;
        pred_next       = pred_reg;
        done_next       = done_reg;
        wr_next         = wr_reg;
        drv_next        = drv_reg;
        upd_next        = upd_reg;
        adapt_next      = adapt_reg;
        err_next        = err_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (cmd.load_in)
        begin
            in_next = in_item;
        end

        if (cmd.step_phase)
        begin
            wr_next    = 1'b0;
            drv_next   = '0;
            upd_next   = 1'b0;
            adapt_next = 1'b0;
            err_next   = err_w[17:0];
            if (!done_reg)
            begin
                phase_now_next = next_phase_reg;
                case (next_phase_reg)
                    radc_pkg::PH_WAIT_FWD:
                    begin
                        wr_next    = entry_reg;
                        entry_next = 1'b0;
                        if (pos_w >= min_hi)
                        begin
                            next_phase_next = radc_pkg::PH_DRIVE_FWD;
                            entry_next      = 1'b1;
                        end
                    end
                    radc_pkg::PH_DRIVE_FWD:
                    begin
                        wr_next    = 1'b1;
                        drv_next   = level_reg;
                        entry_next = 1'b0;
                        if (at_min)
                        begin
                            next_phase_next = radc_pkg::PH_WAIT_FWD;
                            entry_next      = 1'b1;
                        end
                        else if (at_max)
                        begin
                            next_phase_next = radc_pkg::PH_WAIT_BWD;
                            entry_next      = 1'b1;
                        end
                    end
                    radc_pkg::PH_WAIT_BWD:
                    begin
                        wr_next    = entry_reg;
                        entry_next = 1'b0;
                        if (pos_w <= max_lo)
                        begin
                            next_phase_next = radc_pkg::PH_DRIVE_BWD;
                            entry_next      = 1'b1;
                        end
                    end
                    radc_pkg::PH_DRIVE_BWD:
                    begin
                        wr_next    = 1'b1;
                        drv_next   = (level_reg == radc_pkg::LEVEL_MIN) ? radc_pkg::LEVEL_MAX
                                                                     : -level_reg;
                        entry_next = 1'b0;
                        if (at_max)
                        begin
                            next_phase_next = radc_pkg::PH_WAIT_BWD;
                            entry_next      = 1'b1;
                        end
                        else if (at_min)
                        begin
                            next_phase_next = radc_pkg::PH_WAIT_FWD;
                            entry_next      = 1'b1;
                            if (cyc_reg != radc_pkg::CYCLE_MAX)
                            begin
                                cyc_next = cyc_reg + 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                        wr_next = 1'b0;
                    end
                endcase

                upd_next   = in_reg.speed_ready;
                adapt_next = in_reg.speed_ready && (diff < des_w);
                if (in_reg.speed_ready && (diff < des_w))
                begin
                    pred_next = (diff > 19'sd0) ? pn_a[17:0] : pn_b[17:0];
                end
            end
        end

        if (cmd.mult)
        begin
            prod_next = 32'(radc_pkg::GAIN_Q16) * 32'(err_reg) + radc_pkg::OFFSET_Q16;
        end

        if (cmd.level && !done_reg)
        begin
            if (upd_reg)
            begin
                if (!adapt_reg)
                begin
                    level_next = radc_pkg::IDLE_LEVEL;
                end
                else if (coef >= radc_pkg::LEVEL_SAT_C)
                begin
                    level_next = radc_pkg::LEVEL_MAX;
                end
                else
                begin
                    level_next = scaled;
                end
            end
            if (cyc_reg >= reps_reg)
            begin
                done_next = 1'b1;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next            = 1'b1;
            out_item_next.drive_write = wr_reg;
            out_item_next.drive       = wr_reg ? drv_reg : 16'sd0;
            out_item_next.phase       = phase_now_reg;
            out_item_next.cycles_done = cyc_reg;
            out_item_next.finished    = done_reg;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                radc_pkg::CFG_START_POS: start_next   = $signed(cfg_data);
                radc_pkg::CFG_END_POS:   end_next     = $signed(cfg_data);
                radc_pkg::CFG_REPS:      reps_next    = cfg_data[15:0];
                radc_pkg::CFG_DESIRED:   desired_next = cfg_data[15:0];
                radc_pkg::CFG_INIT_DRV:  level_next   = $signed(cfg_data[15:0]);
                default:                 start_next   = start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= radc_pkg::START_POS_RST;
            end_reg        <= radc_pkg::END_POS_RST;
            reps_reg       <= radc_pkg::REPS_RST;
            desired_reg    <= '0;
            phase_now_reg  <= radc_pkg::PH_WAIT_FWD;
            next_phase_reg <= radc_pkg::PH_WAIT_FWD;
            entry_reg      <= 1'b1;
            cyc_reg        <= '0;
            level_reg      <= '0;
            pred_reg       <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_reg      <= start_next;
            end_reg        <= end_next;
            reps_reg       <= reps_next;
            desired_reg    <= desired_next;
            phase_now_reg  <= phase_now_next;
            next_phase_reg <= next_phase_next;
            entry_reg      <= entry_next;
            cyc_reg        <= cyc_next;
            level_reg      <= level_next;
            pred_reg       <= pred_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        wr_reg       <= wr_next;
        drv_reg      <= drv_next;
        upd_reg      <= upd_next;
        adapt_reg    <= adapt_next;
        err_reg      <= err_next;
        prod_reg     <= prod_next;
        out_item_reg <= out_item_next;
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

`default_nettype wire

[design/radc_ctrl.sv]
// Sequencer: steps one item through phase update, gain multiply, level
// scaling and result load. Depends on radc_pkg; drives radc_datapath.
`default_nettype none

module radc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output radc_pkg::dp_cmd_t         cmd,
    input  wire radc_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PHASE = 5'b00010,
        S_MULT  = 5'b00100,
        S_LEVEL = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && !status.out_busy);
        accept   = in_valid && in_ready;

        cmd.load_in    = accept;
        cmd.step_phase = state_reg == S_PHASE;
        cmd.mult       = state_reg == S_MULT;
        cmd.level      = state_reg == S_LEVEL;
        cmd.load_out   = (state_reg == S_OUT) && !status.out_busy;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE: state_next = S_MULT;
            S_MULT:  state_next = S_LEVEL;
            S_LEVEL: state_next = S_OUT;
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = accept ? S_PHASE : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/reciprocating_assist_drive_control.sv]
// Top level of the reciprocating assist drive control block.
// Depends on radc_pkg, radc_ctrl and radc_datapath.
//
// One item per servo tick: position and speed in, one result out (drive
// write strobe, signed drive, executed phase, cycle count, finished flag).
// The sequencer walks each accepted item through phase update, gain
// multiply, level scaling and result load into the result register, and
// when results are taken promptly, the next item is accepted in
// the cycle the result is loaded. A result left waiting in the output
// register holds the sequencer in its load step. Configuration writes act
// at once and belong in idle time; writing initial_drive also loads the
// drive level.
`default_nettype none

module reciprocating_assist_drive_control (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire radc_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output radc_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_we,
    input  wire logic [radc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [radc_pkg::CFG_DATA_W-1:0] cfg_data
);

    radc_pkg::dp_cmd_t    cmd;
    radc_pkg::dp_status_t status;

    radc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    radc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

[design/radc_checker.sv]
// Port-level checker for the reciprocating assist drive control, bound to
// the top level. Depends on radc_pkg and the defines header.
`default_nettype none

`include "reciprocating_assist_drive_control_defines.svh"

module radc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire radc_pkg::out_item_t out_item
);

    // held result must not change
    `RADC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // no drive value without a write strobe
    `RADC_ASSERT_SAME(a_drive_zero, out_valid && !out_item.drive_write, out_item.drive == 16'sd0)

    // one item at a time
    `RADC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    // fixed latency when the result register stays empty after the item is taken
    `RADC_ASSERT_NEXT(a_latency, in_valid && in_ready && !out_valid ##1 !out_valid, ##3 out_valid)

endmodule

bind reciprocating_assist_drive_control radc_checker u_radc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

[test/reciprocating_assist_drive_control_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for reciprocating_assist_drive_control: directed and stroke-shaped
// random ticks, randomly stalled valid/ready channels, checked against an in-bench predictor.
// Depends on radc_pkg and the RTL of the block only.

module reciprocating_assist_drive_control_tb;

    import radc_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint POS_MOST     = 64'sd2147483647;
    localparam longint POS_LEAST    = -64'sd2147483648;
    localparam longint TRAVEL_FLOOR = 50;
    localparam longint TRAVEL_CEIL  = 17000;
    localparam longint EDGE_MARGIN  = 50;
    localparam longint Q16_GAIN     = 28161;
    localparam longint Q16_OFFSET   = 753664;
    localparam logic signed [15:0] COAST_LEVEL = 16'sd12;
    localparam logic signed [15:0] DRIVE_MAX   = 16'sh7fff;
    localparam logic signed [15:0] DRIVE_MIN   = 16'sh8000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and state
    logic signed [31:0] cfg_start;
    logic signed [31:0] cfg_end;
    logic [15:0]        cfg_reps;
    logic [15:0]        cfg_desired;
    logic signed [15:0] cfg_init;
    logic [1:0]         phase_st;
    logic [1:0]         next_st;
    bit                 entry_st;
    logic [15:0]        cycle_st;
    logic signed [15:0] level_st;
    int                 pred_st;
    bit                 done_st;

    in_item_t  tick_q[$];
    out_item_t due_results[$];
    out_item_t want_item;
    int        queued_cnt  = 0;
    int        errors      = 0;
    int        cycle_cnt   = 0;
    bit        in_taken    = 1'b0;
    bit        out_taken   = 1'b0;
    bit        no_idle     = 1'b0;
    int        src_wait    = 0;
    int        sink_wait   = 0;
    int        sink_draw;
    int        stall_token = 0;
    int        stall_seen  = 0;

    reciprocating_assist_drive_control u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint travel_lo();
        return (longint'(cfg_start) < TRAVEL_FLOOR) ? TRAVEL_FLOOR : longint'(cfg_start);
    endfunction

    function automatic longint travel_hi();
        return (longint'(cfg_end) > TRAVEL_CEIL) ? TRAVEL_CEIL : longint'(cfg_end);
    endfunction

    function automatic void enter_phase(logic [1:0] ph);
        next_st  = ph;
        entry_st = 1'b1;
    endfunction

    function automatic out_item_t assist_tick(in_item_t it);
        out_item_t          r;
        longint             pos, spd, lo, hi, d, diff, e, c;
        logic               wr;
        logic signed [15:0] drv;
        pos = longint'($signed(it.position));
        spd = longint'(it.speed);
        wr  = 1'b0;
        drv = '0;
        if (!done_st) begin
            lo       = travel_lo();
            hi       = travel_hi();
            phase_st = next_st;
            case (phase_st)
                PH_WAIT_FWD:
                begin
                    if (entry_st) begin
                        wr       = 1'b1;
                        entry_st = 1'b0;
                    end
                    if (pos >= lo + EDGE_MARGIN) enter_phase(PH_DRIVE_FWD);
                end
                PH_DRIVE_FWD:
                begin
                    entry_st = 1'b0;
                    wr       = 1'b1;
                    drv      = level_st;
                    if (pos <= lo) enter_phase(PH_WAIT_FWD);
                    else if (pos >= hi) enter_phase(PH_WAIT_BWD);
                end
                PH_WAIT_BWD:
                begin
                    if (entry_st) begin
                        wr       = 1'b1;
                        entry_st = 1'b0;
                    end
                    if (pos <= hi - EDGE_MARGIN) enter_phase(PH_DRIVE_BWD);
                end
                default:
                begin
                    entry_st = 1'b0;
                    wr       = 1'b1;
                    drv      = (level_st == DRIVE_MIN) ? DRIVE_MAX : -level_st;
                    if (pos >= hi) enter_phase(PH_WAIT_BWD);
                    else if (pos <= lo) begin
                        enter_phase(PH_WAIT_FWD);
                        if (cycle_st != 16'hffff) cycle_st = cycle_st + 16'd1;
                    end
                end
            endcase

            if (it.speed_ready) begin
                d    = longint'(cfg_desired);
                diff = spd - longint'(pred_st);
                if (diff < d) begin
                    e = d - diff;
                    c = (Q16_GAIN * e + Q16_OFFSET) / 65536;
                    c = (32768 * c) / 100;
                    if (c > 32767) level_st = DRIVE_MAX;
                    else if (c < -32768) level_st = DRIVE_MIN;
                    else level_st = c[15:0];
                    pred_st = (diff > 0) ? int'(d - diff) : int'(d - spd);
                end else begin
                    level_st = COAST_LEVEL;
                end
            end

            if (cycle_st >= cfg_reps) done_st = 1'b1;
        end
        r.drive_write = wr;
        r.drive       = wr ? drv : 16'sd0;
        r.phase       = phase_st;
        r.cycles_done = cycle_st;
        r.finished    = done_st;
        return r;
    endfunction

    // sender: items change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (in_taken) due_results.push_back(assist_tick(in_item));
            if (!in_valid || in_taken) begin
                if (src_wait != 0) begin
                    in_valid <= 1'b0;
                    src_wait <= src_wait - 1;
                end else if (tick_q.size() != 0) begin
                    in_item  <= tick_q.pop_front();
                    in_valid <= 1'b1;
                    src_wait <= no_idle ? 0 : $urandom_range(0, 13);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end else if (stall_seen != stall_token) begin
            stall_seen <= stall_token;
            sink_wait  <= 400;
            out_ready  <= 1'b0;
        end else if (out_taken) begin
            sink_draw = no_idle ? 0 : $urandom_range(0, 13);
            sink_wait <= sink_draw;
            out_ready <= (sink_draw == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            out_ready <= (sink_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_field(string fname, longint want, longint got);
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
        errors++;
    endtask

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken  <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected item: expected none, actual %p", $time, out_item);
                errors++;
            end else begin
                want_item = due_results.pop_front();
                if (out_item.drive_write !== want_item.drive_write)
                    report_field("drive_write", want_item.drive_write, out_item.drive_write);
                if (out_item.drive !== want_item.drive)
                    report_field("drive", want_item.drive, out_item.drive);
                if (out_item.phase !== want_item.phase)
                    report_field("phase", want_item.phase, out_item.phase);
                if (out_item.cycles_done !== want_item.cycles_done)
                    report_field("cycles_done", want_item.cycles_done, out_item.cycles_done);
                if (out_item.finished !== want_item.finished)
                    report_field("finished", want_item.finished, out_item.finished);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL reciprocating_assist_drive_control");
        $finish;
    end

    function automatic logic signed [31:0] clip32(longint p);
        if (p > POS_MOST) return 32'sh7fffffff;
        if (p < POS_LEAST) return 32'sh80000000;
        return p[31:0];
    endfunction

    function automatic void queue_tick(longint pos, int spd, bit rdy);
        in_item_t it;
        it.position    = clip32(pos);
        it.speed       = spd[15:0];
        it.speed_ready = rdy;
        tick_q.push_back(it);
        queued_cnt++;
    endfunction

    function automatic int pick_speed();
        int s;
        case ($urandom_range(0, 3))
            0, 1:    s = int'(cfg_desired) + int'($urandom_range(0, 200)) - 100;
            2:       s = int'($urandom_range(0, 65535));
            default: s = int'($urandom_range(0, 600));
        endcase
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
        return s;
    endfunction

    function automatic longint landmark();
        longint lo, hi;
        lo = travel_lo();
        hi = travel_hi();
        case ($urandom_range(0, 10))
            0:       return lo - 1;
            1:       return lo;
            2:       return lo + 49;
            3:       return lo + 50;
            4:       return hi - 50;
            5:       return hi - 49;
            6:       return hi;
            7:       return hi + 1;
            8:       return longint'($signed($urandom));
            9:       return POS_LEAST;
            default: return POS_MOST;
        endcase
    endfunction

    // one forward and backward sweep reaching or passing both travel ends
    function automatic void queue_stroke();
        longint lo, hi, top, bottom, jit;
        int     n_up, n_dn;
        lo     = travel_lo();
        hi     = travel_hi();
        top    = hi + longint'($urandom_range(0, 120));
        bottom = lo - longint'($urandom_range(0, 120));
        n_up   = $urandom_range(1, 6);
        n_dn   = $urandom_range(1, 6);
        for (int k = 1; k <= n_up; k++) begin
            jit = (k == n_up) ? 0 : longint'($urandom_range(0, 60)) - 30;
            queue_tick(lo + (top - lo) * k / n_up + jit, pick_speed(), $urandom_range(0, 7) != 0);
        end
        for (int k = 1; k <= n_dn; k++) begin
            jit = (k == n_dn) ? 0 : longint'($urandom_range(0, 60)) - 30;
            queue_tick(top + (bottom - top) * k / n_dn + jit, pick_speed(),
                       $urandom_range(0, 7) != 0);
        end
    endfunction

    task automatic queue_random(int n);
        int stop_at;
        stop_at = queued_cnt + n;
        while (queued_cnt < stop_at) begin
            if ($urandom_range(0, 4) != 0) queue_stroke();
            else queue_tick(landmark(), pick_speed(), $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic settle();
        while (tick_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_START_POS: cfg_start = val;
            CFG_END_POS:   cfg_end = val;
            CFG_REPS:      cfg_reps = val[15:0];
            CFG_DESIRED:   cfg_desired = val[15:0];
            CFG_INIT_DRV:
            begin
                cfg_init = val[15:0];
                level_st = val[15:0];
            end
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] s, logic [31:0] e, logic [15:0] r, logic [15:0] d,
                             logic [15:0] i);
        settle();
        write_reg(CFG_START_POS, s);
        write_reg(CFG_END_POS, e);
        write_reg(CFG_REPS, {16'd0, r});
        write_reg(CFG_DESIRED, {16'd0, d});
        write_reg(CFG_INIT_DRV, {16'd0, i});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        cfg_start   = 32'sd50;
        cfg_end     = 32'sd17000;
        cfg_reps    = 16'd1;
        cfg_desired = 16'd0;
        cfg_init    = 16'sd0;
        phase_st    = PH_WAIT_FWD;
        next_st     = PH_WAIT_FWD;
        entry_st    = 1'b1;
        cycle_st    = 16'd0;
        level_st    = 16'sd0;
        pred_st     = 0;
        done_st     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clamped extremes of both travel ends
        configure(32'h80000000, 32'h7fffffff, 16'hffff, 16'd300, 16'h7fff);
        queue_tick(POS_LEAST, 0, 0);
        queue_tick(99, 0, 0);
        queue_tick(100, 0, 0);
        queue_tick(5000, 0, 0);
        queue_tick(17000, 0, 1);
        queue_tick(16951, 65535, 1);
        queue_tick(16950, 600, 1);
        queue_tick(8000, 599, 1);
        queue_tick(17000, 0, 0);
        queue_tick(POS_MOST, 0, 0);
        queue_tick(0, 65535, 1);
        queue_tick(50, 300, 1);
        queue_tick(100, 0, 1);
        queue_tick(51, 0, 1);
        queue_tick(50, 0, 1);
        queue_tick(POS_MOST, 65535, 1);
        queue_tick(17001, 1, 1);
        queue_tick(-1, 0, 1);
        queue_tick(POS_LEAST, 65535, 0);
        queue_random(300);

        // most negative level: backward drive saturates; long receiver hold-off
        configure(32'd1000, 32'd5000, 16'hffff, 16'd0, 16'h8000);
        stall_token++;
        queue_tick(1050, 0, 0);
        queue_tick(5000, 0, 0);
        queue_tick(4950, 0, 0);
        queue_tick(3000, 0, 0);
        queue_tick(1000, 0, 0);
        queue_random(300);

        // crossed travel ends
        configure(32'd12000, 32'd3000, 16'hffff, 16'hffff, 16'd100);
        queue_random(250);

        configure(int'($urandom_range(0, 3100)) - 100, $urandom_range(10000, 20000), 16'hffff,
                  $urandom_range(0, 2000), $urandom_range(0, 65535));
        no_idle = 1'b1;
        queue_random(500);
        settle();
        no_idle = 1'b0;

        // narrow travel, thresholds overlap
        configure(32'd8000, 32'd8100, 16'hffff, 16'd1000, 16'hfffb);
        queue_random(250);

        // count up to the repetition limit, then ticks after finishing
        settle();
        configure(cfg_start, cfg_end, cycle_st + 16'd2, cfg_desired, cfg_init);
        repeat (8) queue_stroke();

        configure(32'h7fffffff, 32'h80000000, 16'd0, 16'hffff, 16'd0);
        for (int k = 0; k < 15; k++)
            queue_tick(landmark(), pick_speed(), $urandom_range(0, 1));

        settle();
        if (errors == 0)
            $display("PASS reciprocating_assist_drive_control");
        else
            $display("FAIL reciprocating_assist_drive_control");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/radc_pkg.sv
design/radc_datapath.sv
design/radc_ctrl.sv
design/reciprocating_assist_drive_control.sv
design/radc_checker.sv
test/reciprocating_assist_drive_control_tb.sv
